[src/satl_pkg.sv]
// Package for the set-associative cache tag store with LRU replacement.
// Holds default geometry, item structs, register indexes and shared types.
// Used by the lookup, top-level and checker modules; depends on nothing.
package satl_pkg;

  localparam int unsigned DefWays      = 2;
  localparam int unsigned DefSets      = 256;
  localparam int unsigned DefLineBytes = 64;
  localparam int unsigned DefAddrBits  = 64;

  localparam logic [31:0] HitLatencyReset  = 32'd1;
  localparam logic [31:0] MissPenaltyReset = 32'd10;

  typedef enum logic {
    CFG_HIT_LATENCY  = 1'b0,
    CFG_MISS_PENALTY = 1'b1
  } satl_cfg_idx_t;

  typedef struct packed {
    logic [63:0] address;
    logic        speculative;
    logic [63:0] start_cycle;
    logic [31:0] next_level_latency;
  } satl_in_t;

  typedef struct packed {
    logic        hit;
    logic [32:0] latency;
    logic [63:0] finish_cycle;
    logic [63:0] access_count;
    logic [63:0] hit_count;
    logic [63:0] miss_count;
    logic [63:0] fill_count;
  } satl_out_t;

  typedef struct packed {
    logic hit;
    logic fill;
  } satl_lookup_t;

endpackage

[src/satl_ram.sv]
// Simple dual-port synchronous RAM with a registered read, one write port.
// Used for the tag rows and for the valid and recency rows; no dependencies.
module satl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/satl_lookup.sv]
// Tag compare, victim choice and true-LRU promotion for one set row.
// Depends on satl_pkg for the lookup status struct.
module satl_lookup #(
  parameter int unsigned WAYS  = 2,
  parameter int unsigned TAG_W = 50,
  parameter int unsigned LRU_W = 1
) (
  input  logic [TAG_W-1:0]            tag,
  input  logic                        spec,
  input  logic [WAYS*TAG_W-1:0]       tag_row,
  input  logic [WAYS*(LRU_W+1)-1:0]   meta_row,
  output satl_pkg::satl_lookup_t      status,
  output logic [WAYS*TAG_W-1:0]       tag_row_next,
  output logic [WAYS*(LRU_W+1)-1:0]   meta_row_next
);
  import satl_pkg::*;

  logic [WAYS-1:0]  valid;
  logic [WAYS-1:0]  valid_next;
  logic [LRU_W-1:0] order      [WAYS];
  logic [LRU_W-1:0] order_next [WAYS];
  logic             hit;
  logic [LRU_W-1:0] hit_way;
  logic             inv_found;
  logic [LRU_W-1:0] inv_way;
  logic [LRU_W-1:0] victim;
  logic [LRU_W-1:0] tgt_way;
  logic             fill;
  logic             found;
  logic [LRU_W-1:0] pos;

  always_comb begin
    valid = meta_row[WAYS-1:0];
    for (int w = 0; w < WAYS; w++) begin
      order[w] = meta_row[WAYS + w*LRU_W +: LRU_W];
    end

    hit = 1'b0;
    hit_way = '0;
    inv_found = 1'b0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid[w] && (tag_row[w*TAG_W +: TAG_W] == tag)) begin
        hit = 1'b1;
        hit_way = LRU_W'(w);
      end
      if (!valid[w]) begin
        inv_found = 1'b1;
        inv_way = LRU_W'(w);
      end
    end

    victim = inv_found ? inv_way : order[WAYS-1];
    fill = !hit && !spec;
    tgt_way = hit ? hit_way : victim;

    found = 1'b0;
    pos = '0;
    for (int p = WAYS - 1; p >= 0; p--) begin
      if (order[p] == tgt_way) begin
        found = 1'b1;
        pos = LRU_W'(p);
      end
    end

    order_next[0] = (!spec && found) ? tgt_way : order[0];
    for (int p = 1; p < WAYS; p++) begin
      if (!spec && found && (LRU_W'(p) <= pos)) begin
        order_next[p] = order[p-1];
      end else begin
        order_next[p] = order[p];
      end
    end

    valid_next = valid;
    tag_row_next = tag_row;
    if (fill) begin
      valid_next[victim] = 1'b1;
      tag_row_next[victim*TAG_W +: TAG_W] = tag;
    end

    meta_row_next[WAYS-1:0] = valid_next;
    for (int w = 0; w < WAYS; w++) begin
      meta_row_next[WAYS + w*LRU_W +: LRU_W] = order_next[w];
    end

    status.hit = hit;
    status.fill = fill;
  end

endmodule

[src/set_assoc_cache_tag_lru.sv]
// Set-associative cache tag store with true LRU replacement, timing only.
//
// Use: an access item enters on the req channel (valid/ready) and one
// result item leaves on the rsp channel (valid/ready) for every access. The user
// must write the two latency registers through the cfg port only while the block
// is idle (it does not enforce this); both reset to the default values in satl_pkg.
//
// Each access reads the set row from the tag RAM and the valid/recency RAM
// at the accepting edge; in the lookup state, once the output register is
// free, the row is compared, updated and written back while the result is
// loaded into the output register. One access is in flight at a time, so
// a new item is not accepted until the read-modify-write of the last
// item's single set row is done.
//
// After reset a clearing pass writes every valid/recency row, one set per
// cycle; req_ready stays low until it ends. If the receiver stalls, the
// result waits in the output register and one further access may be
// accepted; its write-back then waits until the output frees.
module set_assoc_cache_tag_lru #(
  parameter int unsigned WAYS       = satl_pkg::DefWays,
  parameter int unsigned SETS       = satl_pkg::DefSets,
  parameter int unsigned LINE_BYTES = satl_pkg::DefLineBytes,
  parameter int unsigned ADDR_BITS  = satl_pkg::DefAddrBits
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  satl_pkg::satl_in_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output satl_pkg::satl_out_t rsp,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wr_data
);
  import satl_pkg::*;

  localparam int unsigned OFFSET_W   = $clog2(LINE_BYTES + 1) - 1;
  localparam int unsigned SET_SHIFT  = $clog2(SETS + 1) - 1;
  localparam int unsigned TAG_LSB    = OFFSET_W + SET_SHIFT;
  localparam int          TAG_RAW    = int'(ADDR_BITS) - int'(TAG_LSB);
  localparam int unsigned TAG_W      = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int unsigned IDX_W      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned LRU_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned META_W     = WAYS * (LRU_W + 1);
  localparam logic [63:0] ADDR_MASK  =
    (ADDR_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [IDX_W-1:0] SET_LAST = IDX_W'(SETS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [31:0]      hit_latency;
  logic [31:0]      miss_penalty;
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic             spec_q;
  logic [63:0]      now_q;
  logic [31:0]      down_q;
  logic [63:0]      accesses_total;
  logic [63:0]      hits_total;
  logic [63:0]      misses_total;
  logic [63:0]      fills_total;

  logic [63:0]             addr_m;
  logic [IDX_W-1:0]        set_in;
  logic [TAG_W-1:0]        tag_in;
  logic                    req_fire;
  logic                    done;
  logic [WAYS*TAG_W-1:0]   tag_rdata;
  logic [WAYS*TAG_W-1:0]   tag_wdata;
  logic [META_W-1:0]       meta_rdata;
  logic [META_W-1:0]       meta_upd;
  logic [META_W-1:0]       meta_wdata;
  logic [META_W-1:0]       meta_identity;
  logic [IDX_W-1:0]        meta_waddr;
  logic                    meta_we;
  satl_lookup_t            status;
  logic [32:0]             lat;
  logic [63:0]             acc_next;
  logic [63:0]             hits_next;
  logic [63:0]             misses_next;
  logic [63:0]             fills_next;

  assign addr_m   = req.address & ADDR_MASK;
  assign set_in   = IDX_W'(addr_m >> OFFSET_W) & SET_LAST;
  assign tag_in   = TAG_W'(addr_m >> TAG_LSB);
  assign req_ready = (state == ST_IDLE);
  assign req_fire = req_valid && req_ready;
  assign done     = (state == ST_LOOKUP) && (!rsp_valid || rsp_ready);

  always_comb begin
    meta_identity = '0;
    for (int w = 0; w < WAYS; w++) begin
      meta_identity[WAYS + w*LRU_W +: LRU_W] = LRU_W'(w);
    end
  end

  assign meta_we    = (state == ST_CLEAR) || done;
  assign meta_waddr = (state == ST_CLEAR) ? clr_idx : set_q;
  assign meta_wdata = (state == ST_CLEAR) ? meta_identity : meta_upd;

  satl_ram #(
    .WIDTH (WAYS * TAG_W),
    .DEPTH (SETS),
    .AW    (IDX_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (done),
    .waddr (set_q),
    .wdata (tag_wdata),
    .re    (req_fire),
    .raddr (set_in),
    .rdata (tag_rdata)
  );

  satl_ram #(
    .WIDTH (META_W),
    .DEPTH (SETS),
    .AW    (IDX_W)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (req_fire),
    .raddr (set_in),
    .rdata (meta_rdata)
  );

  satl_lookup #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .LRU_W (LRU_W)
  ) u_lookup (
    .tag           (tag_q),
    .spec          (spec_q),
    .tag_row       (tag_rdata),
    .meta_row      (meta_rdata),
    .status        (status),
    .tag_row_next  (tag_wdata),
    .meta_row_next (meta_upd)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == SET_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    if (status.hit) begin
      lat = {1'b0, hit_latency};
    end else begin
      lat = {1'b0, miss_penalty} + {1'b0, down_q};
    end
    acc_next    = accesses_total + 64'd1;
    hits_next   = hits_total + {63'd0, status.hit};
    misses_next = misses_total + {63'd0, !status.hit};
    fills_next  = fills_total + {63'd0, status.fill};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      rsp_valid      <= 1'b0;
      hit_latency    <= HitLatencyReset;
      miss_penalty   <= MissPenaltyReset;
      accesses_total <= '0;
      hits_total     <= '0;
      misses_total   <= '0;
      fills_total    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_HIT_LATENCY:  hit_latency  <= cfg_wr_data;
          CFG_MISS_PENALTY: miss_penalty <= cfg_wr_data;
          default: ;
        endcase
      end
      if (done) begin
        rsp_valid      <= 1'b1;
        accesses_total <= acc_next;
        hits_total     <= hits_next;
        misses_total   <= misses_next;
        fills_total    <= fills_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      set_q  <= set_in;
      tag_q  <= tag_in;
      spec_q <= req.speculative;
      now_q  <= req.start_cycle;
      down_q <= req.next_level_latency;
    end
    if (done) begin
      rsp.hit          <= status.hit;
      rsp.latency      <= lat;
      rsp.finish_cycle <= now_q + {31'd0, lat};
      rsp.access_count <= acc_next;
      rsp.hit_count    <= hits_next;
      rsp.miss_count   <= misses_next;
      rsp.fill_count   <= fills_next;
    end
  end

endmodule

[src/satl_checker.sv]
// Port-level checker for the cache tag store, bound to the top level.
// Depends on satl_pkg for the result item struct.
module satl_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input satl_pkg::satl_out_t rsp
);
  import satl_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("Stalled result item changed or was dropped.");

  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.hit_count + rsp.miss_count) == rsp.access_count)
    else $error("Hit and miss counts do not add up to the access count.");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready)
    else $error("Item accepted before the clearing pass.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("Second item accepted while one is in flight.");

endmodule

bind set_assoc_cache_tag_lru satl_checker u_satl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
